FILE: design/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and types for the max timeslice scheduler.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int ENTRY_COUNT = 8;
   localparam int TICK_BITS   = 16;
   localparam int IDX_BITS    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int CNT_BITS    = $clog2(ENTRY_COUNT + 2);
   localparam int ENTRY_BITS  = 2 * TICK_BITS + 2;

   localparam logic MODE_WRITE    = 1'b0;
   localparam logic MODE_SCHEDULE = 1'b1;

   typedef struct packed {
      logic [TICK_BITS-1:0] ticks;
      logic [TICK_BITS-1:0] refill;
      logic                 blocked;
      logic                 asleep;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REFILL,
      ST_FINISH
   } state_type;

   // one candidate presented to the best-entry tracker
   typedef struct packed {
      logic                 clear;
      logic                 sample;
      logic                 eligible;
      logic [TICK_BITS-1:0] ticks;
      logic [IDX_BITS-1:0]  idx;
   } cand_type;

   typedef struct packed {
      logic                any;
      logic [IDX_BITS-1:0] pick;
   } best_type;

endpackage

FILE: design/mts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mts_best.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_best
// Tracks the first eligible entry with the greatest nonzero ticks over a scan.
// ----------------------------------------------------------------------------
module mts_best (
   input  logic              clock,
   input  logic              reset,
   input  mts_pkg::cand_type cand,
   output mts_pkg::best_type best
);
   import mts_pkg::*;

   logic                 any_ff;
   logic                 any_in;
   logic [TICK_BITS-1:0] top_ff;
   logic [TICK_BITS-1:0] top_in;
   logic [IDX_BITS-1:0]  pick_ff;
   logic [IDX_BITS-1:0]  pick_in;

   always_comb begin
      any_in  = any_ff;
      top_in  = top_ff;
      pick_in = pick_ff;
      if (cand.clear) begin
         any_in = 1'b0;
         top_in = '0;
      end else if (cand.sample && cand.eligible && (cand.ticks > top_ff)) begin
         any_in  = 1'b1;
         top_in  = cand.ticks;
         pick_in = cand.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else begin
         any_ff <= any_in;
      end
      top_ff  <= top_in;
      pick_ff <= pick_in;
   end

   assign best.any  = any_ff;
   assign best.pick = pick_ff;

endmodule

FILE: design/mts_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_seq
// Sequencer: table writes, scan and refill passes over the entry RAM,
// valid bits, current choice and the result register.
// ----------------------------------------------------------------------------
module mts_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [2:0]                       req_entry_index,
   input  logic [15:0]                      req_ticks_value,
   input  logic [15:0]                      req_priority_value,
   input  logic                             req_blocked_value,
   input  logic                             req_asleep_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_chosen_index,
   output logic                             rsp_found,
   output logic                             rsp_refilled,
   output logic                             mem_we,
   output logic [mts_pkg::IDX_BITS-1:0]     mem_waddr,
   output mts_pkg::entry_type               mem_wdata,
   output logic                             mem_re,
   output logic [mts_pkg::IDX_BITS-1:0]     mem_raddr,
   input  mts_pkg::entry_type               mem_rdata,
   output mts_pkg::cand_type                cand,
   input  mts_pkg::best_type                best
);
   import mts_pkg::*;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ENTRY_COUNT + 1);
   localparam logic [CNT_BITS-1:0] CNT_READS = CNT_BITS'(ENTRY_COUNT);

   state_type            state_ff;
   state_type            state_in;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [CNT_BITS-1:0]  cnt_in;
   logic [IDX_BITS-1:0]  choice_ff;
   logic [IDX_BITS-1:0]  choice_in;
   logic                 fnd_ff;
   logic                 fnd_in;
   logic                 rfl_ff;
   logic                 rfl_in;
   logic                 samp_ff;
   logic [IDX_BITS-1:0]  samp_addr_ff;
   logic                 samp_vld_ff;
   logic [ENTRY_COUNT-1:0] valid_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_load;
   logic [2:0]           rsp_chosen_ff;
   logic                 rsp_found_ff;
   logic                 rsp_refilled_ff;
   entry_type            q;
   logic                 zero_ticks;

   // entries never written read as zero
   assign q          = samp_vld_ff ? mem_rdata : '0;
   assign zero_ticks = (q.ticks == '0);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      choice_in  = choice_ff;
      fnd_in     = fnd_ff;
      rfl_in     = rfl_ff;
      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = IDX_BITS'(req_entry_index);
      mem_wdata  = '{ticks:   TICK_BITS'(req_ticks_value),
                     refill:  TICK_BITS'(req_priority_value),
                     blocked: req_blocked_value,
                     asleep:  req_asleep_value};
      mem_re     = 1'b0;
      mem_raddr  = cnt_ff[IDX_BITS-1:0];
      cand.clear    = 1'b0;
      cand.sample   = samp_ff;
      cand.eligible = !q.blocked && !q.asleep;
      cand.ticks    = ((state_ff == ST_REFILL) && zero_ticks) ? q.refill : q.ticks;
      cand.idx      = samp_addr_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               fnd_in = 1'b0;
               rfl_in = 1'b0;
               if (req_mode == MODE_WRITE) begin
                  mem_we   = (32'(req_entry_index) < ENTRY_COUNT);
                  state_in = ST_FINISH;
               end else begin
                  cnt_in     = '0;
                  cand.clear = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN, ST_REFILL: begin
            mem_re = (cnt_ff < CNT_READS);
            if ((state_ff == ST_REFILL) && samp_ff && zero_ticks) begin
               mem_we    = 1'b1;
               mem_waddr = samp_addr_ff;
               mem_wdata = '{ticks: q.refill, refill: q.refill,
                             blocked: q.blocked, asleep: q.asleep};
            end
            if (cnt_ff == CNT_LAST) begin
               if ((state_ff == ST_SCAN) && !best.any) begin
                  cnt_in     = '0;
                  cand.clear = 1'b1;
                  rfl_in     = 1'b1;
                  state_in   = ST_REFILL;
               end else begin
                  fnd_in   = best.any;
                  state_in = ST_FINISH;
                  if (best.any) begin
                     choice_in = best.pick;
                  end
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         choice_ff    <= '0;
         fnd_ff       <= 1'b0;
         rfl_ff       <= 1'b0;
         samp_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         choice_ff    <= choice_in;
         fnd_ff       <= fnd_in;
         rfl_ff       <= rfl_in;
         samp_ff      <= mem_re;
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
      end
      samp_addr_ff <= mem_raddr;
      samp_vld_ff  <= valid_ff[mem_raddr];
      if (rsp_load) begin
         rsp_chosen_ff   <= 3'(choice_ff);
         rsp_found_ff    <= fnd_ff;
         rsp_refilled_ff <= rfl_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_chosen_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_refilled     = rsp_refilled_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LAST)
      else $error("scan counter out of range");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !mem_we)
      else $error("table written during first scan");

   a_refill_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REFILL) |-> rfl_ff)
      else $error("refill pass without refilled flag");

endmodule

FILE: design/max_timeslice_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_timeslice_scheduler_unit
// Greatest remaining timeslice scheduler over a small entry table.
// ----------------------------------------------------------------------------
// The entry table lives in one RAM with a registered read, and a
// sequencer walks it one entry per cycle. A write transfer is accepted and
// then gives its result. A schedule transfer reads every entry once through
// the single RAM read port, and when that first scan finds no eligible entry
// a refill pass reads every entry once more.
// One item is in work at a time; a finished result waits in an output
// register until taken. While a result is held the next item still runs, but
// it waits at its end until the held result is taken, and no further item is
// accepted meanwhile.
// Entries never written read as zero through per-entry valid bits, so no
// clearing pass is needed after reset.
module max_timeslice_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [2:0]  req_entry_index,
   input  logic [15:0] req_ticks_value,
   input  logic [15:0] req_priority_value,
   input  logic        req_blocked_value,
   input  logic        req_asleep_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_chosen_index,
   output logic        rsp_found,
   output logic        rsp_refilled
);
   import mts_pkg::*;

   logic                mem_we;
   logic [IDX_BITS-1:0] mem_waddr;
   entry_type           mem_wdata;
   logic                mem_re;
   logic [IDX_BITS-1:0] mem_raddr;
   entry_type           mem_rdata;
   cand_type            cand;
   best_type            best;

   mts_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRY_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   mts_best u_best (
      .clock (clock),
      .reset (reset),
      .cand  (cand),
      .best  (best)
   );

   mts_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_entry_index    (req_entry_index),
      .req_ticks_value    (req_ticks_value),
      .req_priority_value (req_priority_value),
      .req_blocked_value  (req_blocked_value),
      .req_asleep_value   (req_asleep_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_found          (rsp_found),
      .rsp_refilled       (rsp_refilled),
      .mem_we             (mem_we),
      .mem_waddr          (mem_waddr),
      .mem_wdata          (mem_wdata),
      .mem_re             (mem_re),
      .mem_raddr          (mem_raddr),
      .mem_rdata          (mem_rdata),
      .cand               (cand),
      .best               (best)
   );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the max timeslice scheduler against its own table predictor.
// Directed entry writes and decisions cover ties, blocked and sleeping
// entries, the refill pass and the no-candidate case. Random write bursts,
// each closed by a decision, follow, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import mts_pkg::*;

   typedef struct {
      logic                 mode;
      logic [2:0]           idx;
      logic [TICK_BITS-1:0] ticks;
      logic [TICK_BITS-1:0] prio;
      logic                 blk;
      logic                 slp;
      logic                 drain_first;
   } req_item_type;

   typedef struct {
      logic [2:0] chosen;
      logic       found;
      logic       refilled;
   } decision_type;

   typedef enum logic [1:0] {
      RCV_ALWAYS,
      RCV_MOSTLY,
      RCV_PERIODIC,
      RCV_COIN
   } rcv_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = MODE_WRITE;
   logic [2:0]  req_entry_index = '0;
   logic [15:0] req_ticks_value = '0;
   logic [15:0] req_priority_value = '0;
   logic        req_blocked_value = 1'b0;
   logic        req_asleep_value = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_chosen_index;
   logic        rsp_found;
   logic        rsp_refilled;

   max_timeslice_scheduler_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_entry_index    (req_entry_index),
      .req_ticks_value    (req_ticks_value),
      .req_priority_value (req_priority_value),
      .req_blocked_value  (req_blocked_value),
      .req_asleep_value   (req_asleep_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_found          (rsp_found),
      .rsp_refilled       (rsp_refilled)
   );

   always #6 clock = ~clock;

   req_item_type        pending_items[$];
   decision_type        expected_decisions[$];
   entry_type           sched_entry [ENTRY_COUNT];
   logic [IDX_BITS-1:0] last_choice;

   int error_count = 0;
   int write_count = 0;
   int decide_count = 0;
   int found_count = 0;
   int refill_count = 0;
   int idle_refill_count = 0;
   int drain_count = 0;

   logic          req_accepted = 1'b0;
   int            gap_left = 0;
   int            burst_left = 0;
   int            rcv_cycle = 0;
   rcv_style_type rcv_style = RCV_ALWAYS;

   // ---------------- predictor ----------------
   function automatic best_type find_best();
      best_type             b;
      logic [TICK_BITS-1:0] best_ticks;
      b.any = 1'b0;
      b.pick = '0;
      best_ticks = '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (!sched_entry[i].blocked && !sched_entry[i].asleep &&
             sched_entry[i].ticks > best_ticks) begin
            best_ticks = sched_entry[i].ticks;
            b.pick = i[IDX_BITS-1:0];
            b.any = 1'b1;
         end
      end
      return b;
   endfunction

   function automatic decision_type decide_item(req_item_type it);
      decision_type d;
      best_type     b;
      d.found = 1'b0;
      d.refilled = 1'b0;
      if (it.mode == MODE_WRITE) begin
         if (it.idx < ENTRY_COUNT) begin
            sched_entry[it.idx].ticks = it.ticks;
            sched_entry[it.idx].refill = it.prio;
            sched_entry[it.idx].blocked = it.blk;
            sched_entry[it.idx].asleep = it.slp;
         end
      end else begin
         b = find_best();
         if (!b.any) begin
            d.refilled = 1'b1;
            for (int i = 0; i < ENTRY_COUNT; i++)
               if (sched_entry[i].ticks == '0)
                  sched_entry[i].ticks = sched_entry[i].refill;
            b = find_best();
         end
         if (b.any) begin
            d.found = 1'b1;
            last_choice = b.pick;
         end
      end
      d.chosen = 3'(last_choice);
      return d;
   endfunction

   // ---------------- monitor ----------------
   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
      end
   endtask

   always @(posedge clock) begin
      decision_type want;
      req_item_type it;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_decisions.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual index %0d found %0d",
                        $time, rsp_chosen_index, rsp_found);
            end else begin
               want = expected_decisions.pop_front();
               check_field("chosen_index", want.chosen, rsp_chosen_index);
               check_field("found", want.found, rsp_found);
               check_field("refilled", want.refilled, rsp_refilled);
            end
         end
         if (req_valid && req_ready) begin
            it.mode = req_mode;
            it.idx = req_entry_index;
            it.ticks = req_ticks_value;
            it.prio = req_priority_value;
            it.blk = req_blocked_value;
            it.slp = req_asleep_value;
            it.drain_first = 1'b0;
            want = decide_item(it);
            expected_decisions.push_back(want);
            if (req_mode == MODE_WRITE) begin
               write_count++;
            end else begin
               decide_count++;
               if (want.found) found_count++;
               if (want.refilled) refill_count++;
               if (want.refilled && !want.found) idle_refill_count++;
            end
         end
      end
   end

   // ---------------- driver ----------------
   always @(negedge clock) begin
      req_item_type it;
      if (!reset) begin
         if (req_valid && !req_accepted) begin
            // hold until transfer
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_items[0].drain_first && expected_decisions.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            it = pending_items.pop_front();
            if (it.drain_first) drain_count++;
            req_valid <= 1'b1;
            req_mode <= it.mode;
            req_entry_index <= it.idx;
            req_ticks_value <= it.ticks;
            req_priority_value <= it.prio;
            req_blocked_value <= it.blk;
            req_asleep_value <= it.slp;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      rcv_cycle <= rcv_cycle + 1;
      if (rcv_cycle % 256 == 0) rcv_style <= rcv_style_type'($urandom_range(0, 3));
      case (rcv_style)
         RCV_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RCV_MOSTLY: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         RCV_PERIODIC: begin
            rsp_ready <= ((rcv_cycle % 8) < 3);
         end
         default: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
      endcase
   end

   // ---------------- stimulus ----------------
   task automatic add_item(logic mode, logic [2:0] idx, logic [15:0] ticks,
                           logic [15:0] prio, logic blk, logic slp, logic drain);
      req_item_type it;
      it.mode = mode;
      it.idx = idx;
      it.ticks = ticks;
      it.prio = prio;
      it.blk = blk;
      it.slp = slp;
      it.drain_first = drain;
      pending_items.push_back(it);
   endtask

   function automatic logic [15:0] pick_ticks();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'($urandom_range(1, 4));
         2: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      for (int i = 0; i < ENTRY_COUNT; i++) sched_entry[i] = '0;
      last_choice = '0;

      // empty table: refill finds nothing
      add_item(MODE_SCHEDULE, 3'd0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd7, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd0, 16'hFFFF, 16'h0001, 1'b0, 1'b0, 1'b0);
      // tie goes to the lowest index
      add_item(MODE_SCHEDULE, 3'd5, 16'h1234, 16'h4321, 1'b1, 1'b1, 1'b0);
      add_item(MODE_WRITE, 3'd0, 16'hFFFF, 16'h0001, 1'b1, 1'b0, 1'b0);
      add_item(MODE_SCHEDULE, 3'd0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd7, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
      // nothing eligible even after refill, choice kept
      add_item(MODE_SCHEDULE, 3'd0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd3, 16'h0000, 16'd40, 1'b0, 1'b0, 1'b0);
      add_item(MODE_SCHEDULE, 3'd0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1);
      add_item(MODE_WRITE, 3'd5, 16'h0000, 16'hAAAA, 1'b1, 1'b1, 1'b0);
      add_item(MODE_WRITE, 3'd2, 16'h0000, 16'h5555, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd4, 16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0);
      add_item(MODE_SCHEDULE, 3'd0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd1, 16'd40, 16'h0000, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd2, 16'd40, 16'h5555, 1'b0, 1'b0, 1'b0);
      add_item(MODE_SCHEDULE, 3'd0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0);
      add_item(MODE_WRITE, 3'd6, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0);
      add_item(MODE_SCHEDULE, 3'd0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1);

      // random: write bursts closed by a decision, plus some noise
      while (pending_items.size() < 1470) begin
         if ($urandom_range(0, 6) != 0) begin
            repeat ($urandom_range(0, 4))
               add_item(MODE_WRITE, 3'($urandom_range(0, 7)), pick_ticks(), pick_ticks(),
                        $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0, 1'b0);
            add_item(MODE_SCHEDULE, 3'($urandom_range(0, 7)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 60) == 0);
         end else begin
            add_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_decisions.size() == 0);
      repeat (40) @(posedge clock);
      if (expected_decisions.size() != 0) begin
         error_count++;
         $display("%0t: results missing, expected %0d more, actual 0", $time,
                  expected_decisions.size());
      end

      $display("run covered %0d entry writes and %0d decisions (%0d picked an entry)",
               write_count, decide_count, found_count);
      $display("refill pass ran %0d times, %0d of them with no entry left; %0d drain pauses",
               refill_count, idle_refill_count, drain_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
